// ===== sv/bsss_pkg.sv =====
package bsss_pkg;

   // Sizes of the block.
   localparam int MAX_PRIMS    = 64;
   localparam int BUCKET_COUNT = 12;
   localparam int MEDIAN_LIMIT = 2;
   localparam int COORD_BITS   = 32;

   localparam int IDX_W  = $clog2(MAX_PRIMS);
   localparam int CNT_W  = $clog2(MAX_PRIMS + 1);
   localparam int BKT_W  = $clog2(BUCKET_COUNT);
   localparam int QW     = $clog2(BUCKET_COUNT + 1);
   localparam int QSW    = (QW > 1) ? $clog2(QW) : 1;
   localparam int STEP_W = 4;
   localparam int CCW    = COORD_BITS + 1;
   localparam int DW     = COORD_BITS + 2;
   localparam int XW     = COORD_BITS + 1;
   localparam int NUMW   = XW + QW;
   localparam int PROD_W = 2 * COORD_BITS;
   localparam int AREA_W = PROD_W + 2;
   localparam int SCL_W  = AREA_W + CNT_W;
   localparam int COST_W = SCL_W + 1;
   localparam int MUL_STEPS = 7;

   // Split mode codes.
   localparam logic [2:0] MODE_SINGLE    = 3'd0;
   localparam logic [2:0] MODE_DEGEN     = 3'd1;
   localparam logic [2:0] MODE_MEDIAN    = 3'd2;
   localparam logic [2:0] MODE_SAH_SPLIT = 3'd3;
   localparam logic [2:0] MODE_SAH_LEAF  = 3'd4;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   typedef struct packed {
      logic [2:0][COORD_BITS-1:0] lo;
      logic [2:0][COORD_BITS-1:0] hi;
   } box_type;

   typedef enum logic [3:0] {
      ST_LOAD, ST_DECIDE, ST_RD, ST_PREP, ST_DIV, ST_UPD, ST_SCAN_INIT,
      ST_ACC, ST_EXT, ST_MUL, ST_SCALE, ST_CMP, ST_EMIT
   } state_type;

   typedef enum logic [3:0] {
      OP_IDLE, OP_DECIDE, OP_RD, OP_PREP, OP_DIV, OP_UPD, OP_SCAN_INIT,
      OP_ACC, OP_EXT, OP_MUL, OP_SCALE, OP_CMP, OP_EMIT
   } op_type;

   typedef struct packed {
      op_type op;
      logic   accept;
   } cmd_type;

   typedef struct packed {
      logic last_xfer;
      logic need_bin;
      logic step_done;
      logic idx_last;
      logic split_last;
      logic out_free;
   } status_type;

endpackage

// ===== sv/bsss_if.sv =====
interface bsss_box_if;
   import bsss_pkg::*;
   logic valid;
   logic ready;
   logic signed [COORD_BITS-1:0] box_low_x;
   logic signed [COORD_BITS-1:0] box_low_y;
   logic signed [COORD_BITS-1:0] box_low_z;
   logic signed [COORD_BITS-1:0] box_high_x;
   logic signed [COORD_BITS-1:0] box_high_y;
   logic signed [COORD_BITS-1:0] box_high_z;
   logic last_prim;
   modport source (output valid, box_low_x, box_low_y, box_low_z, box_high_x, box_high_y,
                   box_high_z, last_prim, input ready);
   modport sink (input valid, box_low_x, box_low_y, box_low_z, box_high_x, box_high_y,
                 box_high_z, last_prim, output ready);
endinterface

interface bsss_split_if;
   import bsss_pkg::*;
   logic valid;
   logic ready;
   logic [2:0] split_mode;
   logic [1:0] cut_axis;
   logic [3:0] split_bucket;
   logic [6:0] left_count;
   logic [6:0] prim_count;
   logic signed [COORD_BITS-1:0] node_low_x;
   logic signed [COORD_BITS-1:0] node_low_y;
   logic signed [COORD_BITS-1:0] node_low_z;
   logic signed [COORD_BITS-1:0] node_high_x;
   logic signed [COORD_BITS-1:0] node_high_y;
   logic signed [COORD_BITS-1:0] node_high_z;
   modport source (output valid, split_mode, cut_axis, split_bucket, left_count, prim_count,
                   node_low_x, node_low_y, node_low_z, node_high_x, node_high_y, node_high_z,
                   input ready);
   modport sink (input valid, split_mode, cut_axis, split_bucket, left_count, prim_count,
                 node_low_x, node_low_y, node_low_z, node_high_x, node_high_y, node_high_z,
                 output ready);
endinterface

interface bsss_csr_if;
   logic valid;
   logic ready;
   logic [6:0] max_leaf_count;
   modport source (output valid, max_leaf_count, input ready);
   modport sink (input valid, max_leaf_count, output ready);
endinterface

// ===== sv/bsss_ctrl.sv =====
module bsss_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  bsss_pkg::status_type status,
   output bsss_pkg::cmd_type    cmd
);
   import bsss_pkg::*;

   state_type state_ff, state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD:      if (status.last_xfer) state_in = ST_DECIDE;
         ST_DECIDE:    state_in = status.need_bin ? ST_RD : ST_EMIT;
         ST_RD:        state_in = ST_PREP;
         ST_PREP:      state_in = ST_DIV;
         ST_DIV:       if (status.step_done) state_in = ST_UPD;
         ST_UPD:       state_in = status.idx_last ? ST_SCAN_INIT : ST_RD;
         ST_SCAN_INIT: state_in = ST_ACC;
         ST_ACC:       if (status.step_done) state_in = ST_EXT;
         ST_EXT:       state_in = ST_MUL;
         ST_MUL:       if (status.step_done) state_in = ST_SCALE;
         ST_SCALE:     state_in = ST_CMP;
         ST_CMP:       state_in = status.split_last ? ST_EMIT : ST_SCAN_INIT;
         ST_EMIT:      if (status.out_free) state_in = ST_LOAD;
         default:      state_in = ST_LOAD;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd.accept = 1'b0;
      cmd.op     = OP_IDLE;
      case (state_ff)
         ST_LOAD:      cmd.accept = 1'b1;
         ST_DECIDE:    cmd.op = OP_DECIDE;
         ST_RD:        cmd.op = OP_RD;
         ST_PREP:      cmd.op = OP_PREP;
         ST_DIV:       cmd.op = OP_DIV;
         ST_UPD:       cmd.op = OP_UPD;
         ST_SCAN_INIT: cmd.op = OP_SCAN_INIT;
         ST_ACC:       cmd.op = OP_ACC;
         ST_EXT:       cmd.op = OP_EXT;
         ST_MUL:       cmd.op = OP_MUL;
         ST_SCALE:     cmd.op = OP_SCALE;
         ST_CMP:       cmd.op = OP_CMP;
         ST_EMIT:      cmd.op = OP_EMIT;
         default:      cmd.op = OP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/bsss_dp.sv =====
module bsss_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  bsss_pkg::cmd_type    cmd,
   output bsss_pkg::status_type status,
   bsss_box_if.sink             req_chan,
   bsss_split_if.source         rsp_chan,
   bsss_csr_if.sink             csr_chan
);
   import bsss_pkg::*;

   localparam logic [COORD_BITS-1:0] C_TOP = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic [COORD_BITS-1:0] C_BOT = {1'b1, {(COORD_BITS-1){1'b0}}};
   localparam logic [CCW-1:0] CC_TOP = {1'b0, {(CCW-1){1'b1}}};
   localparam logic [CCW-1:0] CC_BOT = {1'b1, {(CCW-1){1'b0}}};

   // Node state.
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   box_type node_ff, node_in;
   logic [2:0][CCW-1:0] cen_lo_ff, cen_lo_in, cen_hi_ff, cen_hi_in;
   logic [6:0] max_leaf_ff, max_leaf_in;
   // Decision registers.
   logic [1:0] axis_ff, axis_in;
   logic [XW-1:0] den_ff, den_in;
   logic [CCW-1:0] cmin_ff, cmin_in;
   logic [2:0] mode_ff, mode_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic binned_ff, binned_in;
   // Binning.
   logic [IDX_W-1:0] idx_ff, idx_in;
   box_type rd_ff;
   logic [NUMW-1:0] rem_ff, rem_in;
   logic [QW-1:0] q_ff, q_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [BUCKET_COUNT-1:0][CNT_W-1:0] bkt_cnt_ff, bkt_cnt_in;
   logic [BUCKET_COUNT-1:0] bkt_vld_ff, bkt_vld_in;
   box_type [BUCKET_COUNT-1:0] bkt_box_ff, bkt_box_in;
   // Cost scan.
   box_type lb_ff, lb_in, rb_ff, rb_in;
   logic [CNT_W-1:0] lc_ff, lc_in, rc_ff, rc_in;
   logic [5:0][COORD_BITS-1:0] ext_ff, ext_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [AREA_W-1:0] area_l_ff, area_l_in, area_r_ff, area_r_in;
   logic [SCL_W-1:0] cost_l_ff, cost_l_in, cost_r_ff, cost_r_in;
   logic [COST_W-1:0] best_ff, best_in;
   logic [CNT_W-1:0] best_left_ff, best_left_in;
   logic [BKT_W-1:0] s_ff, s_in, bucket_ff, bucket_in;
   // Output register.
   logic rsp_valid_ff, rsp_valid_in;
   logic [2:0] o_mode_ff, o_mode_in;
   logic [1:0] o_axis_ff, o_axis_in;
   logic [BKT_W-1:0] o_bucket_ff, o_bucket_in;
   logic [CNT_W-1:0] o_left_ff, o_left_in, o_cnt_ff, o_cnt_in;
   box_type o_node_ff, o_node_in;

   box_type box_in;
   logic xfer, out_free;
   box_type mem [MAX_PRIMS];

   assign box_in.lo = {req_chan.box_low_z, req_chan.box_low_y, req_chan.box_low_x};
   assign box_in.hi = {req_chan.box_high_z, req_chan.box_high_y, req_chan.box_high_x};
   assign req_chan.ready = cmd.accept;
   assign xfer = req_chan.valid && cmd.accept;
   assign csr_chan.ready = 1'b1;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // Merge of a box into running bounds.
   function automatic box_type merge(box_type a, box_type b);
      box_type r;
      r = a;
      for (int k = 0; k < 3; k++) begin
         if ($signed(b.lo[k]) < $signed(a.lo[k])) r.lo[k] = b.lo[k];
         if ($signed(b.hi[k]) > $signed(a.hi[k])) r.hi[k] = b.hi[k];
      end
      return r;
   endfunction

   function automatic box_type empty_box();
      box_type r;
      for (int k = 0; k < 3; k++) begin
         r.lo[k] = C_TOP;
         r.hi[k] = C_BOT;
      end
      return r;
   endfunction

   // Decision terms of the centroid bounds.
   logic [2:0][DW-1:0] dext;
   logic [1:0] axis_sel;
   logic [DW-1:0] dsel;
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         dext[k] = DW'($signed(cen_hi_ff[k])) - DW'($signed(cen_lo_ff[k]));
      end
      if ($signed(dext[0]) > $signed(dext[1]) && $signed(dext[0]) > $signed(dext[2])) begin
         axis_sel = AXIS_X;
      end else if ($signed(dext[1]) > $signed(dext[2])) begin
         axis_sel = AXIS_Y;
      end else begin
         axis_sel = AXIS_Z;
      end
      dsel = dext[axis_sel];
   end

   // Next values of the datapath registers.
   always_comb begin
      logic [CCW-1:0] c;
      logic [CCW-1:0] xd;
      logic [NUMW-1:0] sub;
      logic [QSW-1:0] sh;
      logic [BKT_W-1:0] b;
      logic [BKT_W-1:0] ai;
      logic [COORD_BITS-1:0] ma, mb;
      logic [COORD_BITS:0] df;
      logic [COST_W-1:0] cost;
      box_type lbx, rbx;
      cnt_in = cnt_ff; node_in = node_ff; cen_lo_in = cen_lo_ff; cen_hi_in = cen_hi_ff;
      max_leaf_in = max_leaf_ff; axis_in = axis_ff; den_in = den_ff; cmin_in = cmin_ff;
      mode_in = mode_ff; left_in = left_ff; binned_in = binned_ff; idx_in = idx_ff;
      rem_in = rem_ff; q_in = q_ff; step_in = step_ff; bkt_cnt_in = bkt_cnt_ff;
      bkt_vld_in = bkt_vld_ff; bkt_box_in = bkt_box_ff; lb_in = lb_ff; rb_in = rb_ff;
      lc_in = lc_ff; rc_in = rc_ff; ext_in = ext_ff; prod_in = prod_ff;
      area_l_in = area_l_ff; area_r_in = area_r_ff; cost_l_in = cost_l_ff;
      cost_r_in = cost_r_ff; best_in = best_ff; best_left_in = best_left_ff;
      s_in = s_ff; bucket_in = bucket_ff; rsp_valid_in = rsp_valid_ff;
      o_mode_in = o_mode_ff; o_axis_in = o_axis_ff; o_bucket_in = o_bucket_ff;
      o_left_in = o_left_ff; o_cnt_in = o_cnt_ff; o_node_in = o_node_ff;
      c = '0; xd = '0; sub = '0; sh = '0; b = '0; ai = '0; ma = '0; mb = '0; df = '0;
      cost = '0; lbx = lb_ff; rbx = rb_ff;

      if (csr_chan.valid) max_leaf_in = csr_chan.max_leaf_count;
      if (rsp_valid_ff && rsp_chan.ready) rsp_valid_in = 1'b0;

      // Box load: bounds grow, boxes past the store size are dropped.
      if (xfer && cnt_ff < CNT_W'(MAX_PRIMS)) begin
         node_in = merge(node_ff, box_in);
         for (int k = 0; k < 3; k++) begin
            c = CCW'($signed(box_in.lo[k])) + CCW'($signed(box_in.hi[k]));
            if ($signed(c) < $signed(cen_lo_ff[k])) cen_lo_in[k] = c;
            if ($signed(c) > $signed(cen_hi_ff[k])) cen_hi_in[k] = c;
         end
         cnt_in = cnt_ff + CNT_W'(1);
      end

      case (cmd.op)
         OP_DECIDE: begin
            binned_in = 1'b0;
            left_in   = '0;
            bucket_in = '0;
            idx_in    = '0;
            s_in      = '0;
            den_in    = dsel[XW-1:0];
            cmin_in   = cen_lo_ff[axis_sel];
            if (cnt_ff <= CNT_W'(1)) begin
               mode_in = MODE_SINGLE;
               axis_in = AXIS_X;
            end else begin
               axis_in = axis_sel;
               if (dsel == '0) begin
                  mode_in = MODE_DEGEN;
               end else if (cnt_ff <= CNT_W'(MEDIAN_LIMIT)) begin
                  mode_in = MODE_MEDIAN;
                  left_in = cnt_ff >> 1;
               end else begin
                  binned_in = 1'b1;
               end
            end
         end
         OP_PREP: begin
            // Offset of the doubled centroid from the lower centroid bound.
            c  = CCW'($signed(rd_ff.lo[axis_ff])) + CCW'($signed(rd_ff.hi[axis_ff]));
            xd = c - cmin_ff;
            rem_in  = NUMW'(xd) * NUMW'(BUCKET_COUNT);
            q_in    = '0;
            step_in = '0;
         end
         OP_DIV: begin
            // One quotient bit per cycle, most significant first.
            sh  = QSW'(QW - 1) - QSW'(step_ff);
            sub = NUMW'(den_ff) << sh;
            if (rem_ff >= sub) begin
               rem_in   = rem_ff - sub;
               q_in[sh] = 1'b1;
            end
            step_in = step_ff + STEP_W'(1);
         end
         OP_UPD: begin
            b = (q_ff >= QW'(BUCKET_COUNT)) ? BKT_W'(BUCKET_COUNT - 1) : BKT_W'(q_ff);
            bkt_cnt_in[b] = bkt_cnt_ff[b] + CNT_W'(1);
            bkt_vld_in[b] = 1'b1;
            bkt_box_in[b] = bkt_vld_ff[b] ? merge(bkt_box_ff[b], rd_ff) : rd_ff;
            idx_in = idx_ff + IDX_W'(1);
         end
         OP_SCAN_INIT: begin
            lb_in = empty_box();
            rb_in = empty_box();
            lc_in = '0;
            rc_in = '0;
            step_in = '0;
         end
         OP_ACC: begin
            ai = BKT_W'(step_ff);
            if (bkt_vld_ff[ai]) begin
               if (ai <= s_ff) begin
                  lb_in = merge(lb_ff, bkt_box_ff[ai]);
                  lc_in = lc_ff + bkt_cnt_ff[ai];
               end else begin
                  rb_in = merge(rb_ff, bkt_box_ff[ai]);
                  rc_in = rc_ff + bkt_cnt_ff[ai];
               end
            end
            step_in = step_ff + STEP_W'(1);
         end
         OP_EXT: begin
            // Extents of both sides; an inverted extent counts as zero.
            for (int k = 0; k < 3; k++) begin
               df = (COORD_BITS + 1)'($signed(lbx.hi[k])) - (COORD_BITS + 1)'($signed(lbx.lo[k]));
               ext_in[k] = $signed(df) > 0 ? df[COORD_BITS-1:0] : '0;
               df = (COORD_BITS + 1)'($signed(rbx.hi[k])) - (COORD_BITS + 1)'($signed(rbx.lo[k]));
               ext_in[k + 3] = $signed(df) > 0 ? df[COORD_BITS-1:0] : '0;
            end
            step_in   = '0;
            area_l_in = '0;
            area_r_in = '0;
         end
         OP_MUL: begin
            // Shared multiplier: left products first, then right, each added in the next cycle.
            case (step_ff)
               4'd0: begin ma = ext_ff[0]; mb = ext_ff[1]; end
               4'd1: begin ma = ext_ff[1]; mb = ext_ff[2]; end
               4'd2: begin ma = ext_ff[2]; mb = ext_ff[0]; end
               4'd3: begin ma = ext_ff[3]; mb = ext_ff[4]; end
               4'd4: begin ma = ext_ff[4]; mb = ext_ff[5]; end
               4'd5: begin ma = ext_ff[5]; mb = ext_ff[3]; end
               default: begin ma = '0; mb = '0; end
            endcase
            prod_in = PROD_W'(ma) * PROD_W'(mb);
            if (step_ff inside {4'd1, 4'd2, 4'd3}) begin
               area_l_in = area_l_ff + AREA_W'(prod_ff);
            end else if (step_ff inside {4'd4, 4'd5, 4'd6}) begin
               area_r_in = area_r_ff + AREA_W'(prod_ff);
            end
            step_in = step_ff + STEP_W'(1);
         end
         OP_SCALE: begin
            cost_l_in = SCL_W'(area_l_ff) * SCL_W'(lc_ff);
            cost_r_in = SCL_W'(area_r_ff) * SCL_W'(rc_ff);
         end
         OP_CMP: begin
            cost = COST_W'(cost_l_ff) + COST_W'(cost_r_ff);
            if (s_ff == '0 || cost < best_ff) begin
               best_in      = cost;
               bucket_in    = s_ff;
               best_left_in = lc_ff;
            end
            s_in = s_ff + BKT_W'(1);
         end
         OP_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               o_axis_in    = axis_ff;
               o_cnt_in     = cnt_ff;
               o_node_in    = node_ff;
               if (binned_ff) begin
                  o_bucket_in = bucket_ff;
                  if (cnt_ff > CNT_W'(max_leaf_ff)) begin
                     o_mode_in = MODE_SAH_SPLIT;
                     o_left_in = best_left_ff;
                  end else begin
                     o_mode_in = MODE_SAH_LEAF;
                     o_left_in = '0;
                  end
               end else begin
                  o_mode_in   = mode_ff;
                  o_left_in   = left_ff;
                  o_bucket_in = '0;
               end
               // Clear the node for the next set of boxes.
               cnt_in     = '0;
               node_in    = empty_box();
               bkt_vld_in = '0;
               bkt_cnt_in = '0;
               for (int k = 0; k < 3; k++) begin
                  cen_lo_in[k] = CC_TOP;
                  cen_hi_in[k] = CC_BOT;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Status to the controller.
   always_comb begin
      status.last_xfer  = xfer && req_chan.last_prim;
      status.need_bin   = (cnt_ff > CNT_W'(MEDIAN_LIMIT)) && (dsel != '0);
      status.idx_last   = (CNT_W'(idx_ff) + CNT_W'(1)) == cnt_ff;
      status.split_last = s_ff == BKT_W'(BUCKET_COUNT - 2);
      status.out_free   = out_free;
      case (cmd.op)
         OP_DIV:  status.step_done = step_ff == STEP_W'(QW - 1);
         OP_ACC:  status.step_done = step_ff == STEP_W'(BUCKET_COUNT - 1);
         OP_MUL:  status.step_done = step_ff == STEP_W'(MUL_STEPS - 1);
         default: status.step_done = 1'b0;
      endcase
   end

   // Box store: written on load, read once per primitive while binning.
   always_ff @(posedge clock) begin
      if (xfer && cnt_ff < CNT_W'(MAX_PRIMS)) begin
         mem[cnt_ff[IDX_W-1:0]] <= box_in;
      end
      if (cmd.op == OP_RD) begin
         rd_ff <= mem[idx_ff];
      end
   end

   // Control and reset-valued state.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         node_ff      <= empty_box();
         max_leaf_ff  <= 7'd4;
         bkt_vld_ff   <= '0;
         bkt_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            cen_lo_ff[k] <= CC_TOP;
            cen_hi_ff[k] <= CC_BOT;
         end
      end else begin
         cnt_ff       <= cnt_in;
         node_ff      <= node_in;
         max_leaf_ff  <= max_leaf_in;
         bkt_vld_ff   <= bkt_vld_in;
         bkt_cnt_ff   <= bkt_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         cen_lo_ff    <= cen_lo_in;
         cen_hi_ff    <= cen_hi_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      axis_ff <= axis_in; den_ff <= den_in; cmin_ff <= cmin_in; mode_ff <= mode_in;
      left_ff <= left_in; binned_ff <= binned_in; idx_ff <= idx_in; rem_ff <= rem_in;
      q_ff <= q_in; step_ff <= step_in; bkt_box_ff <= bkt_box_in; lb_ff <= lb_in;
      rb_ff <= rb_in; lc_ff <= lc_in; rc_ff <= rc_in; ext_ff <= ext_in;
      prod_ff <= prod_in; area_l_ff <= area_l_in; area_r_ff <= area_r_in;
      cost_l_ff <= cost_l_in; cost_r_ff <= cost_r_in; best_ff <= best_in;
      best_left_ff <= best_left_in; s_ff <= s_in; bucket_ff <= bucket_in;
      o_mode_ff <= o_mode_in; o_axis_ff <= o_axis_in; o_bucket_ff <= o_bucket_in;
      o_left_ff <= o_left_in; o_cnt_ff <= o_cnt_in; o_node_ff <= o_node_in;
   end

   // Result port.
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.split_mode   = o_mode_ff;
   assign rsp_chan.cut_axis     = o_axis_ff;
   assign rsp_chan.split_bucket = 4'(o_bucket_ff);
   assign rsp_chan.left_count   = 7'(o_left_ff);
   assign rsp_chan.prim_count   = 7'(o_cnt_ff);
   assign rsp_chan.node_low_x   = o_node_ff.lo[0];
   assign rsp_chan.node_low_y   = o_node_ff.lo[1];
   assign rsp_chan.node_low_z   = o_node_ff.lo[2];
   assign rsp_chan.node_high_x  = o_node_ff.hi[0];
   assign rsp_chan.node_high_y  = o_node_ff.hi[1];
   assign rsp_chan.node_high_z  = o_node_ff.hi[2];

endmodule

// ===== sv/binned_sah_split_select_core.sv =====
// Binned SAH split selection for one BVH node. Boxes of the node's primitives arrive one per
// transfer on req_chan until a transfer with last_prim set; up to 64 boxes are kept and further
// ones are dropped, though one with last_prim set still ends the node. One result per node
// leaves on rsp_chan through an output register, so the next node loads while a result waits.
// After the last box the block makes a decision; nodes of three or more primitives with nonzero
// centroid extent are then binned (per primitive a box store read, a setup step, the bit-serial
// bucket divider and a bucket update) and scanned over 11 bucket boundaries, whose areas come
// from the shared multiplier of the area sequencer. max_leaf_count on csr_chan is to be written
// only between nodes by the user; the block itself does not enforce it.
module binned_sah_split_select_core (
   input logic          clock,
   input logic          reset,
   bsss_box_if.sink     req_chan,
   bsss_split_if.source rsp_chan,
   bsss_csr_if.sink     csr_chan
);
   import bsss_pkg::*;

   cmd_type    cmd;
   status_type status;

   bsss_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   bsss_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

endmodule

// ===== test/tb_bsss_if.sv =====
`timescale 1ns / 100ps

// Scoreboard for the split selection testbench.
package tb_bsss_sb_pkg;
   import bsss_pkg::*;

   typedef struct {
      logic [2:0]  mode;
      logic [1:0]  axis;
      logic [3:0]  bucket;
      logic [6:0]  left;
      logic [6:0]  count;
      logic [31:0] bnd [6];
   } split_result_type;

   // Predicts node decisions and checks them against results in order.
   class split_scoreboard;
      logic signed [31:0] boxes [MAX_PRIMS][6];
      int          loaded;
      logic signed [33:0] nbnd [6];
      logic signed [33:0] cbnd [6];
      logic [6:0]  leaf_limit;
      split_result_type pending [$];
      int          errors;

      function new();
         leaf_limit = 7'd4;
         errors = 0;
         clear_node();
      endfunction

      function void clear_node();
         loaded = 0;
         for (int k = 0; k < 3; k++) begin
            nbnd[k] = 34'sd2147483647;
            nbnd[k + 3] = -34'sd2147483648;
            cbnd[k] = 34'sd4294967295;
            cbnd[k + 3] = -34'sd4294967296;
         end
      endfunction

      // Half surface area of a box, negative extents as zero.
      function logic [129:0] half_area(logic signed [33:0] b [6]);
         logic [63:0] e [3];
         for (int k = 0; k < 3; k++)
            e[k] = (b[k + 3] > b[k]) ? 64'(b[k + 3] - b[k]) : 64'd0;
         return 130'(e[0]) * e[1] + 130'(e[1]) * e[2] + 130'(e[2]) * e[0];
      endfunction

      // Notes one accepted box; on the last one, queues the expected decision.
      function void note_box(logic signed [31:0] bx [6], logic last);
         split_result_type r;
         logic signed [33:0] d [3];
         logic [6:0] bcnt [BUCKET_COUNT];
         logic signed [33:0] bb [BUCKET_COUNT][6];
         logic signed [33:0] lb [6], rb [6];
         logic signed [33:0] c, cmin;
         logic [129:0] cost, best;
         logic [67:0] q;
         int n, lc, rc, best_left;
         if (loaded < MAX_PRIMS) begin
            for (int k = 0; k < 6; k++) boxes[loaded][k] = bx[k];
            for (int k = 0; k < 3; k++) begin
               if (bx[k] < nbnd[k]) nbnd[k] = bx[k];
               if (bx[k + 3] > nbnd[k + 3]) nbnd[k + 3] = bx[k + 3];
               c = 34'(bx[k]) + 34'(bx[k + 3]);
               if (c < cbnd[k]) cbnd[k] = c;
               if (c > cbnd[k + 3]) cbnd[k + 3] = c;
            end
            loaded++;
         end
         if (!last) return;
         n = loaded;
         r.mode = MODE_SINGLE; r.axis = AXIS_X; r.bucket = 0; r.left = 0;
         r.count = 7'(n);
         if (n > 1) begin
            for (int k = 0; k < 3; k++) d[k] = cbnd[k + 3] - cbnd[k];
            if (d[0] > d[1] && d[0] > d[2]) r.axis = AXIS_X;
            else if (d[1] > d[2]) r.axis = AXIS_Y;
            else r.axis = AXIS_Z;
            if (d[r.axis] == 0) r.mode = MODE_DEGEN;
            else if (n <= MEDIAN_LIMIT) begin
               r.mode = MODE_MEDIAN;
               r.left = 7'(n >> 1);
            end else begin
               cmin = cbnd[r.axis];
               for (int i = 0; i < BUCKET_COUNT; i++) begin
                  bcnt[i] = 0;
                  for (int k = 0; k < 3; k++) begin
                     bb[i][k] = 34'sd2147483647; bb[i][k + 3] = -34'sd2147483648;
                  end
               end
               for (int i = 0; i < n; i++) begin
                  c = 34'(boxes[i][r.axis]) + 34'(boxes[i][r.axis + 3]);
                  q = (68'(BUCKET_COUNT) * 68'(c - cmin)) / 68'(d[r.axis]);
                  if (q >= BUCKET_COUNT) q = BUCKET_COUNT - 1;
                  bcnt[q]++;
                  for (int k = 0; k < 3; k++) begin
                     if (boxes[i][k] < bb[q][k]) bb[q][k] = boxes[i][k];
                     if (boxes[i][k + 3] > bb[q][k + 3]) bb[q][k + 3] = boxes[i][k + 3];
                  end
               end
               best = 0; best_left = 0;
               for (int s = 0; s < BUCKET_COUNT - 1; s++) begin
                  lc = 0; rc = 0;
                  for (int k = 0; k < 3; k++) begin
                     lb[k] = 34'sd2147483647; lb[k + 3] = -34'sd2147483648;
                     rb[k] = lb[k]; rb[k + 3] = lb[k + 3];
                  end
                  for (int i = 0; i < BUCKET_COUNT; i++)
                     for (int k = 0; k < 3; k++)
                        if (i <= s) begin
                           if (bb[i][k] < lb[k]) lb[k] = bb[i][k];
                           if (bb[i][k + 3] > lb[k + 3]) lb[k + 3] = bb[i][k + 3];
                        end else begin
                           if (bb[i][k] < rb[k]) rb[k] = bb[i][k];
                           if (bb[i][k + 3] > rb[k + 3]) rb[k + 3] = bb[i][k + 3];
                        end
                  for (int i = 0; i < BUCKET_COUNT; i++)
                     if (i <= s) lc += bcnt[i]; else rc += bcnt[i];
                  cost = half_area(lb) * lc + half_area(rb) * rc;
                  if (s == 0 || cost < best) begin
                     best = cost; r.bucket = 4'(s); best_left = lc;
                  end
               end
               if (n > leaf_limit) begin
                  r.mode = MODE_SAH_SPLIT; r.left = 7'(best_left);
               end else r.mode = MODE_SAH_LEAF;
            end
         end
         for (int k = 0; k < 6; k++) r.bnd[k] = nbnd[k][31:0];
         pending.push_back(r);
         clear_node();
      endfunction

      task automatic report(string what, logic [31:0] got, logic [31:0] want);
         errors++;
         $display("result error: %s got %0h expected %0h", what, got, want);
      endtask

      // Compares one accepted result with the oldest expectation.
      task automatic check_result(split_result_type g);
         split_result_type w;
         if (pending.size() == 0) begin
            report("unexpected result", 32'd1, 32'd0);
            return;
         end
         w = pending.pop_front();
         if (g.mode !== w.mode) report("split_mode", g.mode, w.mode);
         if (g.axis !== w.axis) report("cut_axis", g.axis, w.axis);
         if (g.bucket !== w.bucket) report("split_bucket", g.bucket, w.bucket);
         if (g.left !== w.left) report("left_count", g.left, w.left);
         if (g.count !== w.count) report("prim_count", g.count, w.count);
         for (int k = 0; k < 6; k++)
            if (g.bnd[k] !== w.bnd[k]) report("node bound", g.bnd[k], w.bnd[k]);
      endtask
   endclass
endpackage

// ===== test/tb_binned_sah_split_select_core.sv =====
`timescale 1ns / 100ps

module tb_binned_sah_split_select_core;
   import bsss_pkg::*;
   import tb_bsss_sb_pkg::*;

   logic clock;
   logic reset;
   bsss_box_if   req_chan ();
   bsss_split_if rsp_chan ();
   bsss_csr_if   csr_chan ();

   split_scoreboard node_sb;
   int  hold_cycles;
   bit  rand_ready;

   binned_sah_split_select_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .csr_chan (csr_chan.sink)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // Sends one box and waits for its transfer. Valid stays high after the
   // transfer, so a following box with no gap is offered in the next cycle.
   task automatic send_box(logic [31:0] b [6], logic last);
      logic signed [31:0] sb [6];
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.box_low_x <= b[0]; req_chan.box_low_y <= b[1]; req_chan.box_low_z <= b[2];
      req_chan.box_high_x <= b[3]; req_chan.box_high_y <= b[4]; req_chan.box_high_z <= b[5];
      req_chan.last_prim <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      for (int k = 0; k < 6; k++) sb[k] = b[k];
      node_sb.note_box(sb, last);
   endtask

   // Random box: mostly small coordinates, sometimes full range or inverted.
   task automatic rand_box(output logic [31:0] b [6]);
      int sel;
      logic [31:0] t;
      sel = $urandom_range(0, 9);
      for (int k = 0; k < 3; k++) begin
         if (sel == 0) begin
            b[k] = $urandom; b[k + 3] = $urandom;
         end else begin
            b[k] = $urandom_range(0, 4000) - 2000;
            b[k + 3] = b[k] + $urandom_range(0, 300);
         end
         if (sel == 1 && k == 0) begin
            t = b[k]; b[k] = b[k + 3]; b[k + 3] = t;
         end
      end
   endtask

   task automatic send_node(int n);
      logic [31:0] b [6];
      for (int i = 0; i < n; i++) begin
         rand_box(b);
         send_box(b, i == n - 1);
      end
   endtask

   // Stops sending and waits until every expected result is in.
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (node_sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_leaf_limit(logic [6:0] v);
      csr_chan.valid <= 1'b1;
      csr_chan.max_leaf_count <= v;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      node_sb.leaf_limit = v;
      csr_chan.valid <= 1'b0;
   endtask

   // Result side: a random wait per result once rand_ready is set, plus one long hold-off.
   initial begin
      split_result_type g;
      int wait_left;
      wait_left = 0;
      rsp_chan.ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready) begin
            g.mode = rsp_chan.split_mode; g.axis = rsp_chan.cut_axis;
            g.bucket = rsp_chan.split_bucket; g.left = rsp_chan.left_count;
            g.count = rsp_chan.prim_count;
            g.bnd[0] = rsp_chan.node_low_x; g.bnd[1] = rsp_chan.node_low_y;
            g.bnd[2] = rsp_chan.node_low_z; g.bnd[3] = rsp_chan.node_high_x;
            g.bnd[4] = rsp_chan.node_high_y; g.bnd[5] = rsp_chan.node_high_z;
            node_sb.check_result(g);
            wait_left = rand_ready ? $urandom_range(0, 13) : 0;
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_chan.ready <= 1'b0;
         end else if (wait_left > 0) begin
            wait_left--;
            rsp_chan.ready <= 1'b0;
         end else rsp_chan.ready <= 1'b1;
      end
   end

   initial begin
      logic [31:0] b [6];
      node_sb = new();
      hold_cycles = 0;
      rand_ready = 0;
      reset = 1'b1;
      req_chan.valid = 1'b0; req_chan.last_prim = 1'b0;
      req_chan.box_low_x = 0; req_chan.box_low_y = 0; req_chan.box_low_z = 0;
      req_chan.box_high_x = 0; req_chan.box_high_y = 0; req_chan.box_high_z = 0;
      csr_chan.valid = 1'b0; csr_chan.max_leaf_count = 7'd4;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: single leaf at extremes, degenerate, median, SAH leaf and split.
      b = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
      send_box(b, 1);
      b = '{0, 0, 0, 10, 10, 10};
      send_box(b, 0); send_box(b, 1);
      b = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
            32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
      send_box(b, 0);
      b = '{0, 0, 0, 0, 0, 0};
      send_box(b, 1);
      send_node(3);
      send_node(5);
      b = '{5, 5, 5, 5, 5, 5};
      for (int i = 0; i < 4; i++) send_box(b, 0);
      b = '{9, 5, 5, 9, 5, 5};
      send_box(b, 1);
      drain();
      write_leaf_limit(7'd1);
      send_node(4);
      drain();

      // Overflow past the store depth.
      write_leaf_limit(7'd64);
      send_node(70);
      drain();

      // Long receiver hold-off while boxes keep coming.
      hold_cycles = 3000;
      for (int i = 0; i < 8; i++) send_node($urandom_range(1, 4));
      drain();

      rand_ready = 1;
      for (int ph = 0; ph < 4; ph++) begin
         write_leaf_limit(ph == 0 ? 7'd1 : ph == 1 ? 7'd64 : 7'($urandom_range(1, 64)));
         for (int nd = 0; nd < 50; nd++)
            send_node($urandom_range(0, 4) == 0 ? $urandom_range(1, 3) :
                      $urandom_range(3, 20));
         drain();
      end

      if (node_sb.errors == 0)
         $display("binned_sah_split_select_core: match");
      else
         $display("binned_sah_split_select_core: mismatch");
      $finish;
   end

   initial begin
      #20ms;
      $display("binned_sah_split_select_core: mismatch");
      $finish;
   end
endmodule

// ===== filelist.f =====
sv/bsss_pkg.sv
sv/bsss_if.sv
sv/bsss_ctrl.sv
sv/bsss_dp.sv
sv/binned_sah_split_select_core.sv
test/tb_bsss_if.sv
test/tb_binned_sah_split_select_core.sv
